@@ rtl/sevseg_pkg.sv @@
// Shared constants, types and the segment pattern table of the seven-segment scan block.
package sevseg_pkg;

  localparam int NUM_DIGITS = 4;
  localparam int POS_W      = $clog2(NUM_DIGITS);
  localparam int CODE_W     = 4;
  localparam int SEG_W      = 8;
  localparam int VALUE_W    = 16;
  localparam int POINT_W    = 3;

  localparam logic [CODE_W-1:0]  ERROR_CODE  = 4'd14;
  localparam logic [SEG_W-1:0]   POINT_BIT   = 8'h20;
  localparam logic [SEG_W-1:0]   SEG_OFF     = 8'hFF;
  localparam logic [POINT_W-1:0] POINT_RESET = 3'd4;
  localparam int                 MAX_VALUE   = 9999;

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_LOAD = 1'b1
  } op_e;

  typedef logic [CODE_W-1:0] code_array_t [NUM_DIGITS];

  typedef struct packed {
    logic fire;
    op_e  op;
  } scan_ctrl_t;

  function automatic logic [SEG_W-1:0] seg_pattern(input logic [CODE_W-1:0] code);
    logic [SEG_W-1:0] pat;
    case (code)
      4'd0:    pat = 8'hD7;
      4'd1:    pat = 8'h11;
      4'd2:    pat = 8'h8F;
      4'd3:    pat = 8'h9B;
      4'd4:    pat = 8'h59;
      4'd5:    pat = 8'hDA;
      4'd6:    pat = 8'hDE;
      4'd7:    pat = 8'h91;
      4'd8:    pat = 8'hDF;
      4'd9:    pat = 8'hDB;
      4'd10:   pat = 8'hDD;
      4'd11:   pat = 8'h5E;
      4'd12:   pat = 8'hC6;
      4'd13:   pat = 8'h1F;
      4'd14:   pat = 8'hCE;
      default: pat = 8'hCC;
    endcase
    return pat;
  endfunction

endpackage

@@ rtl/sevseg_if.sv @@
// Handshake channels for command items and display result items.
interface sevseg_cmd_if;
  import sevseg_pkg::*;
  logic               valid;
  logic               ready;
  logic               op;
  logic [VALUE_W-1:0] value;

  modport source (output valid, output op, output value, input ready);
  modport sink (input valid, input op, input value, output ready);
endinterface

interface sevseg_disp_if;
  import sevseg_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [SEG_W-1:0]      segment_drive;
  logic [NUM_DIGITS-1:0] digit_enable;

  modport source (output valid, output segment_drive, output digit_enable, input ready);
  modport sink (input valid, input segment_drive, input digit_enable, output ready);
endinterface

@@ rtl/seven_segment_scan_with_bcd_core.sv @@
// Top level of the four-digit multiplexed seven-segment driver with decimal load.
// A command item passes through the input register and then the result register.
// Throughput: one item per cycle while the display side is ready, set by the input register and result register pair.
// Reset clears all digit codes to zero, the active position to zero and turns all
// segments off; the decimal point is set to none. No clearing pass is needed.
module seven_segment_scan_with_bcd_core (
  input  logic                           clk,
  input  logic                           rst,
  sevseg_cmd_if.sink                     cmd,
  sevseg_disp_if.source                  disp,
  input  logic                           wr_en,
  input  logic [sevseg_pkg::POINT_W-1:0] wr_data
);
  import sevseg_pkg::*;

  logic               in_valid;
  logic               in_op;
  logic [VALUE_W-1:0] in_value;
  logic               out_valid;
  logic [POINT_W-1:0] point_digit;
  logic               advance;
  scan_ctrl_t         ctrl;
  code_array_t        codes;

  assign advance    = !out_valid || disp.ready;
  assign cmd.ready  = !in_valid || advance;
  assign ctrl.fire  = in_valid && advance;
  assign ctrl.op    = op_e'(in_op);
  assign disp.valid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid    <= 1'b0;
      out_valid   <= 1'b0;
      point_digit <= POINT_RESET;
    end else begin
      if (cmd.ready) begin
        in_valid <= cmd.valid;
      end
      if (advance) begin
        out_valid <= in_valid;
      end
      if (wr_en) begin
        point_digit <= wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      in_op    <= cmd.op;
      in_value <= cmd.value;
    end
  end

  sevseg_bcd u_bcd (
    .value (in_value),
    .codes (codes)
  );

  sevseg_scan u_scan (
    .clk           (clk),
    .rst           (rst),
    .ctrl          (ctrl),
    .codes_in      (codes),
    .point_digit   (point_digit),
    .segment_latch (disp.segment_drive),
    .enable        (disp.digit_enable)
  );

endmodule

@@ rtl/sevseg_bcd.sv @@
// Binary to four-digit decimal conversion with an error pattern for out-of-range values.
module sevseg_bcd (
  input  logic [sevseg_pkg::VALUE_W-1:0] value,
  output sevseg_pkg::code_array_t        codes
);
  import sevseg_pkg::*;

  logic        in_range;
  logic [13:0] v;
  logic [30:0] p10;
  logic [30:0] p100;
  logic [30:0] p1000;
  logic [9:0]  q10;
  logic [6:0]  q100;
  logic [3:0]  q1000;
  logic [13:0] ones;
  logic [9:0]  tens;
  logic [6:0]  hundreds;

  // Quotients come from reciprocal multiplications that are exact below ten thousand.
  always_comb begin
    in_range = !value[VALUE_W-1] && ({1'b0, value[VALUE_W-2:0]} <= VALUE_W'(MAX_VALUE));
    v        = value[13:0];
    p10      = 31'(v) * 31'(52429);
    p100     = 31'(v) * 31'(5243);
    p1000    = 31'(v) * 31'(8389);
    q10      = p10[28:19];
    q100     = p100[25:19];
    q1000    = p1000[26:23];
    ones     = v - 14'(q10) * 14'd10;
    tens     = q10 - 10'(q100) * 10'd10;
    hundreds = q100 - 7'(q1000) * 7'd10;
    if (in_range) begin
      codes[0] = q1000;
      codes[1] = hundreds[3:0];
      codes[2] = tens[3:0];
      codes[3] = ones[3:0];
    end else begin
      codes = '{default: ERROR_CODE};
    end
  end

endmodule

@@ rtl/sevseg_scan.sv @@
// Digit store, active position counter and segment latch of the display scan.
module sevseg_scan (
  input  logic                             clk,
  input  logic                             rst,
  input  sevseg_pkg::scan_ctrl_t           ctrl,
  input  sevseg_pkg::code_array_t          codes_in,
  input  logic [sevseg_pkg::POINT_W-1:0]   point_digit,
  output logic [sevseg_pkg::SEG_W-1:0]     segment_latch,
  output logic [sevseg_pkg::NUM_DIGITS-1:0] enable
);
  import sevseg_pkg::*;

  code_array_t      digit_codes;
  logic [POS_W-1:0] active_position;
  logic [POS_W-1:0] position_next;
  logic [SEG_W-1:0] segment_latch_next;
  logic [SEG_W-1:0] pat;
  logic             point_here;

  always_comb begin
    position_next = (active_position == POS_W'(NUM_DIGITS - 1)) ? '0
                                                                 : active_position + 1'b1;
    pat           = seg_pattern(digit_codes[position_next]);
    point_here    = (point_digit < POINT_W'(NUM_DIGITS)) &&
                    (POINT_W'(position_next) == POINT_W'(NUM_DIGITS - 1) - point_digit);
    segment_latch_next = ~(pat | (point_here ? POINT_BIT : '0));
  end

  always_comb begin
    enable                  = '0;
    enable[active_position] = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      digit_codes     <= '{default: '0};
      active_position <= '0;
      segment_latch   <= SEG_OFF;
    end else if (ctrl.fire) begin
      if (ctrl.op == OP_LOAD) begin
        digit_codes <= codes_in;
      end else begin
        active_position <= position_next;
        segment_latch   <= segment_latch_next;
      end
    end
  end

endmodule

@@ rtl/sevseg_checker.sv @@
// Port-level checks of the seven-segment scan block and their binding to the top level.
module sevseg_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                cmd_valid,
  input logic                                cmd_ready,
  input logic                                disp_valid,
  input logic                                disp_ready,
  input logic [sevseg_pkg::SEG_W-1:0]        disp_segment_drive,
  input logic [sevseg_pkg::NUM_DIGITS-1:0]   disp_digit_enable
);
  import sevseg_pkg::*;

  // Exactly one digit is driven at all times.
  assert property (@(posedge clk) disable iff (rst) $onehot(disp_digit_enable))
    else $error("digit enable is not one-hot");

  // The active digit only ever steps to its neighbour.
  assert property (@(posedge clk) disable iff (rst)
    !$stable(disp_digit_enable) |->
      disp_digit_enable == (NUM_DIGITS'($past(disp_digit_enable) << 1) |
                            NUM_DIGITS'($past(disp_digit_enable) >> (NUM_DIGITS - 1))))
    else $error("active digit skipped a position");

  // With no result waiting, the block always takes a new item.
  assert property (@(posedge clk) disable iff (rst) !disp_valid |-> cmd_ready)
    else $error("command stalled with an empty result stage");

  // A stalled result item keeps its payload.
  assert property (@(posedge clk) disable iff (rst)
    disp_valid && !disp_ready |=> $stable(disp_segment_drive) && $stable(disp_digit_enable))
    else $error("stalled result item changed");

endmodule

bind seven_segment_scan_with_bcd_core sevseg_checker u_checker (
  .clk                (clk),
  .rst                (rst),
  .cmd_valid          (cmd.valid),
  .cmd_ready          (cmd.ready),
  .disp_valid         (disp.valid),
  .disp_ready         (disp.ready),
  .disp_segment_drive (disp.segment_drive),
  .disp_digit_enable  (disp.digit_enable)
);
